/* rtl/core/sxtok_pkg.sv */
// Shared types, character constants and byte class functions for the
// S-expression byte tokenizer. No dependencies.
`default_nettype none

package sxtok_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 4;
    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_KEYWORD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NUMBER  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_STRING  = 3'd5;

    localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SPACE   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_COMMENT = 4'd3;
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 4'd4;
    localparam logic [KIND_W-1:0] KIND_STRING  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_UNREC   = 4'd8;

    localparam logic [BYTE_W-1:0] CH_LPAREN    = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN    = 8'h29;
    localparam logic [BYTE_W-1:0] CH_SEMI      = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_PERIOD    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_UNDER     = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_MINUS     = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_LESS      = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GREATER   = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_QUESTION  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_BANG      = 8'h21;
    localparam logic [BYTE_W-1:0] CH_PLUS      = 8'h2B;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [KIND_W-1:0] token_kind;
        logic              starts_token;
        logic              stream_end;
    } res_t;

    typedef struct packed {
        res_t              res;
        logic [MODE_W-1:0] mode_next;
        logic              odd_next;
    } cls_out_t;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_name_part(input logic [BYTE_W-1:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_UNDER) || (c == CH_MINUS) ||
               (c == CH_STAR) || (c == CH_LESS) || (c == CH_GREATER) ||
               (c == CH_QUESTION) || (c == CH_BANG) || (c == CH_PLUS) ||
               (c == CH_PERIOD);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/sxtok_classify.sv */
// Combinational byte labeler: token kind, start flag and next lexer state.
// Depends on sxtok_pkg.
`default_nettype none

module sxtok_classify
    import sxtok_pkg::*;
(
    input  wire logic [BYTE_W-1:0] byte_in,
    input  wire logic              last_byte,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic              odd,
    output cls_out_t               cls
);

    logic              open_tok;
    logic [KIND_W-1:0] kind;
    logic              starts;
    logic [MODE_W-1:0] mode_n;
    logic              odd_n;

    always_comb
    begin
        open_tok = 1'b0;
        kind     = KIND_UNREC;
        starts   = 1'b0;
        mode_n   = mode;
        odd_n    = odd;

        case (mode)
            MODE_COMMENT:
            begin
                if (byte_in != CH_NEWLINE)
                begin
                    kind     = KIND_COMMENT;
                    open_tok = 1'b1;
                end
            end
            MODE_KEYWORD:
            begin
                if (is_name_part(byte_in))
                begin
                    kind     = KIND_KEYWORD;
                    open_tok = 1'b1;
                end
            end
            MODE_IDENT:
            begin
                if (is_name_part(byte_in))
                begin
                    kind     = KIND_IDENT;
                    open_tok = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(byte_in) || (byte_in == CH_PERIOD))
                begin
                    kind     = KIND_NUMBER;
                    open_tok = 1'b1;
                end
            end
            MODE_STRING:
            begin
                kind     = KIND_STRING;
                open_tok = 1'b1;
                if ((byte_in == CH_QUOTE) && !odd)
                begin
                    mode_n = MODE_IDLE;
                    odd_n  = 1'b0;
                end
                else if (byte_in == CH_BACKSLASH)
                begin
                    odd_n = ~odd;
                end
                else
                begin
                    odd_n = 1'b0;
                end
            end
            default:
            begin
                open_tok = 1'b0;
            end
        endcase

        if (!open_tok)
        begin
            starts = 1'b1;
            mode_n = MODE_IDLE;
            odd_n  = 1'b0;
            if (byte_in == CH_LPAREN)
            begin
                kind = KIND_LPAREN;
            end
            else if (byte_in == CH_RPAREN)
            begin
                kind = KIND_RPAREN;
            end
            else if (byte_in == CH_SEMI)
            begin
                kind   = KIND_COMMENT;
                mode_n = MODE_COMMENT;
            end
            else if (byte_in == CH_COLON)
            begin
                kind   = KIND_KEYWORD;
                mode_n = MODE_KEYWORD;
            end
            else if (byte_in == CH_QUOTE)
            begin
                kind   = KIND_STRING;
                mode_n = MODE_STRING;
            end
            else if (is_space(byte_in))
            begin
                kind = KIND_SPACE;
            end
            else if (is_letter(byte_in))
            begin
                kind   = KIND_IDENT;
                mode_n = MODE_IDENT;
            end
            else if (is_digit(byte_in))
            begin
                kind   = KIND_NUMBER;
                mode_n = MODE_NUMBER;
            end
            else
            begin
                kind = KIND_UNREC;
            end
        end

        if (last_byte)
        begin
            mode_n = MODE_IDLE;
            odd_n  = 1'b0;
        end

        cls.res.byte_out     = byte_in;
        cls.res.token_kind   = kind;
        cls.res.starts_token = starts;
        cls.res.stream_end   = last_byte;
        cls.mode_next        = mode_n;
        cls.odd_next         = odd_n;
    end

endmodule

`default_nettype wire

/* rtl/core/sxtok_skid.sv */
// Result register with a one-entry skid stage; ready is registered.
// Depends on sxtok_pkg.
`default_nettype none

module sxtok_skid
    import sxtok_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire res_t in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_item
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t out_item_reg;
    res_t skid_item_reg;
    logic in_fire;
    logic out_free;

    assign in_ready  = ~skid_valid_reg;
    assign in_fire   = in_valid & ~skid_valid_reg;
    assign out_free  = ~out_valid_reg | out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg | in_fire;
            skid_valid_next = 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
            end
            else if (in_fire)
            begin
                out_item_reg <= in_item;
            end
        end
        else if (in_fire)
        begin
            skid_item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sexpr_byte_tokenizer_core.sv */
// Top level of the S-expression byte tokenizer: lexer state, labeler, output stage.
// Depends on sxtok_pkg, sxtok_classify and sxtok_skid.
//
// One source byte per item in, one labeled byte per item out, in order. The block
// takes a byte every clock while ready is high: the lexer mode and backslash parity
// update in the same cycle the byte is accepted, and the label is registered in the
// result register, or in the skid register while the output stalls. This two-entry
// output stage lets one more byte in while a result waits; ready drops only when both
// entries are full. A byte with tlast set returns the lexer to idle.
`default_nettype none

module sexpr_byte_tokenizer_core
    import sxtok_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] byte_out
    output logic [4:0]       m_axis_tuser,   // [3:0] token_kind, [4] starts_token
    output logic             m_axis_tlast    // stream_end
);

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              odd_reg;
    logic              odd_next;
    logic              in_fire;
    cls_out_t          cls;
    res_t              res_out;

    sxtok_classify u_classify (
        .byte_in   (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .mode      (mode_reg),
        .odd       (odd_reg),
        .cls       (cls)
    );

    assign in_fire   = s_axis_tvalid & s_axis_tready;
    assign mode_next = in_fire ? cls.mode_next : mode_reg;
    assign odd_next  = in_fire ? cls.odd_next : odd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            odd_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            odd_reg  <= odd_next;
        end
    end

    sxtok_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (cls.res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_item  (res_out)
    );

    assign m_axis_tdata = res_out.byte_out;
    assign m_axis_tuser = {res_out.starts_token, res_out.token_kind};
    assign m_axis_tlast = res_out.stream_end;

endmodule

`default_nettype wire

/* rtl/core/sxtok_checker.sv */
// Port-level checks for the S-expression byte tokenizer, bound to the top level.
// Depends on sxtok_pkg.
`default_nettype none

module sxtok_checker
    import sxtok_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [4:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // stalled output item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[3:0] <= KIND_UNREC)
        else $error("token kind out of range");

    // one-byte tokens always open a token
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[3:0] == KIND_LPAREN ||
            m_axis_tuser[3:0] == KIND_RPAREN || m_axis_tuser[3:0] == KIND_SPACE ||
            m_axis_tuser[3:0] == KIND_UNREC) |-> m_axis_tuser[4])
        else $error("single-byte token without start flag");

    // newline never belongs to a comment
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata == CH_NEWLINE |->
            m_axis_tuser[3:0] != KIND_COMMENT)
        else $error("newline labeled as comment");

    // input stalls only behind a waiting item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

endmodule

bind sexpr_byte_tokenizer_core sxtok_checker u_sxtok_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* dv/sexpr_byte_tokenizer_core_test.sv */
// Self-checking testbench for sexpr_byte_tokenizer_core: drives byte streams, predicts
// each token label and compares every labeled byte in order.
// Depends on sxtok_pkg and the tokenizer RTL.
`default_nettype none

module sexpr_byte_tokenizer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sxtok_pkg::*;

    localparam int HOLD_CYCLES = 240;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 270;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [7:0] m_axis_tdata;
    wire logic [4:0] m_axis_tuser;
    wire logic   m_axis_tlast;

    // predictor state
    logic [MODE_W-1:0] lex_state = MODE_IDLE;
    logic              bs_odd = 1'b0;

    res_t label_q [$];
    res_t got_res;
    res_t want_res;
    int   mismatches = 0;
    int   items_sent = 0;
    int   send_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    sexpr_byte_tokenizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic alpha_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic name_byte(input logic [7:0] c);
        return alpha_byte(c) || digit_byte(c) || c == CH_UNDER || c == CH_MINUS ||
               c == CH_STAR || c == CH_LESS || c == CH_GREATER || c == CH_QUESTION ||
               c == CH_BANG || c == CH_PLUS || c == CH_PERIOD;
    endfunction

    // label one byte and advance the lexer copy
    function automatic res_t label_byte(input logic [7:0] c, input logic last);
        res_t r;
        logic cont;
        r.byte_out     = c;
        r.token_kind   = KIND_UNREC;
        r.starts_token = 1'b0;
        r.stream_end   = last;
        cont = 1'b0;
        case (lex_state)
            MODE_COMMENT:
                if (c != CH_NEWLINE)
                begin
                    r.token_kind = KIND_COMMENT;
                    cont = 1'b1;
                end
            MODE_KEYWORD:
                if (name_byte(c))
                begin
                    r.token_kind = KIND_KEYWORD;
                    cont = 1'b1;
                end
            MODE_IDENT:
                if (name_byte(c))
                begin
                    r.token_kind = KIND_IDENT;
                    cont = 1'b1;
                end
            MODE_NUMBER:
                if (digit_byte(c) || c == CH_PERIOD)
                begin
                    r.token_kind = KIND_NUMBER;
                    cont = 1'b1;
                end
            MODE_STRING:
            begin
                r.token_kind = KIND_STRING;
                cont = 1'b1;
                if (c == CH_QUOTE && !bs_odd)
                begin
                    lex_state = MODE_IDLE;
                    bs_odd = 1'b0;
                end
                else if (c == CH_BACKSLASH)
                    bs_odd = ~bs_odd;
                else
                    bs_odd = 1'b0;
            end
            default: ;
        endcase
        if (!cont)
        begin
            r.starts_token = 1'b1;
            lex_state = MODE_IDLE;
            bs_odd = 1'b0;
            if (c == CH_LPAREN)
                r.token_kind = KIND_LPAREN;
            else if (c == CH_RPAREN)
                r.token_kind = KIND_RPAREN;
            else if (c == CH_SEMI)
            begin
                r.token_kind = KIND_COMMENT;
                lex_state = MODE_COMMENT;
            end
            else if (c == CH_COLON)
            begin
                r.token_kind = KIND_KEYWORD;
                lex_state = MODE_KEYWORD;
            end
            else if (c == CH_QUOTE)
            begin
                r.token_kind = KIND_STRING;
                lex_state = MODE_STRING;
            end
            else if (blank_byte(c))
                r.token_kind = KIND_SPACE;
            else if (alpha_byte(c))
            begin
                r.token_kind = KIND_IDENT;
                lex_state = MODE_IDENT;
            end
            else if (digit_byte(c))
            begin
                r.token_kind = KIND_NUMBER;
                lex_state = MODE_NUMBER;
            end
        end
        if (last)
        begin
            lex_state = MODE_IDLE;
            bs_odd = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_name_char();
        case ($urandom_range(3))
            0: return 8'h61 + 8'($urandom_range(25));
            1: return 8'h41 + 8'($urandom_range(25));
            2: return 8'h30 + 8'($urandom_range(9));
            default:
                case ($urandom_range(8))
                    0: return CH_UNDER;
                    1: return CH_MINUS;
                    2: return CH_STAR;
                    3: return CH_LESS;
                    4: return CH_GREATER;
                    5: return CH_QUESTION;
                    6: return CH_BANG;
                    7: return CH_PLUS;
                    default: return CH_PERIOD;
                endcase
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        label_q.insert(label_q.size(), label_byte(b, last));
        items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // send one byte, now and then closing the stream
    task automatic feed(input logic [7:0] b);
        send_byte(b, $urandom_range(59) == 0);
    endtask

    task automatic send_token();
        int n;
        logic [7:0] b;
        n = $urandom_range(6);
        case ($urandom_range(9))
            0: feed($urandom_range(1) ? CH_LPAREN : CH_RPAREN);
            1: feed($urandom_range(1) ? CH_SPACE : 8'(9 + $urandom_range(4)));
            2:
            begin
                feed(CH_SEMI);
                repeat (n)
                begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == CH_NEWLINE);
                    feed(b);
                end
                feed(CH_NEWLINE);
            end
            3:
            begin
                feed(CH_COLON);
                repeat (n)
                    feed(rand_name_char());
            end
            4:
            begin
                feed(8'h61 + 8'($urandom_range(25)));
                repeat (n)
                    feed(rand_name_char());
            end
            5:
            begin
                feed(8'h30 + 8'($urandom_range(9)));
                repeat (n)
                    feed($urandom_range(3) == 0 ? CH_PERIOD : 8'h30 + 8'($urandom_range(9)));
            end
            6, 7:
            begin
                feed(CH_QUOTE);
                repeat (n)
                begin
                    case ($urandom_range(7))
                        0, 1, 2: feed(CH_BACKSLASH);
                        3:
                        begin
                            feed(CH_BACKSLASH);
                            feed(CH_QUOTE);
                        end
                        default:
                        begin
                            do
                                b = 8'($urandom_range(255));
                            while (b == CH_QUOTE);
                            feed(b);
                        end
                    endcase
                end
                feed(CH_QUOTE);
            end
            default:
                repeat (n + 1)
                    feed(8'($urandom_range(255)));
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (label_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [8:0] seq [26];
        seq = '{
            {1'b0, CH_LPAREN}, {1'b0, CH_RPAREN}, {1'b0, CH_SPACE}, {1'b0, CH_SEMI},
            {1'b0, 8'hFF}, {1'b0, CH_NEWLINE}, {1'b0, CH_COLON}, {1'b0, 8'h6B},
            {1'b0, CH_MINUS}, {1'b0, 8'h31}, {1'b0, CH_LPAREN}, {1'b0, 8'h41},
            {1'b0, CH_QUESTION}, {1'b0, 8'h35}, {1'b0, CH_SPACE}, {1'b0, 8'h39},
            {1'b0, CH_PERIOD}, {1'b0, 8'h61}, {1'b0, 8'h00}, {1'b0, 8'h80},
            {1'b0, CH_QUOTE}, {1'b0, CH_BACKSLASH}, {1'b0, CH_QUOTE}, {1'b0, CH_QUOTE},
            {1'b0, CH_QUOTE}, {1'b1, 8'h7F}
        };
        send_idle_pct = 0;
        rx_stall_pct = 0;
        foreach (seq[i])
            send_byte(seq[i][7:0], seq[i][8]);
        wait_drained();
    endtask

    task automatic test_lexeme_mix(input int idle_pct, input int stall_pct);
        int target;
        send_idle_pct = idle_pct;
        rx_stall_pct = stall_pct;
        target = items_sent + PHASE_ITEMS;
        while (items_sent < target)
            send_token();
        wait_drained();
    endtask

    // receiver holds off long enough for the output stage to fill and stall input
    task automatic test_output_full();
        send_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req <= hold_req + 1;
        repeat (50)
            feed(8'($urandom_range(255)));
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res.byte_out     = m_axis_tdata;
            got_res.token_kind   = m_axis_tuser[3:0];
            got_res.starts_token = m_axis_tuser[4];
            got_res.stream_end   = m_axis_tlast;
            if (label_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: byte %h kind %0d start %b end %b",
                             got_res.byte_out, got_res.token_kind,
                             got_res.starts_token, got_res.stream_end);
            end
            else
            begin
                want_res = label_q.pop_front();
                if (got_res.byte_out !== want_res.byte_out ||
                    got_res.token_kind !== want_res.token_kind ||
                    got_res.starts_token !== want_res.starts_token ||
                    got_res.stream_end !== want_res.stream_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: got byte %h kind %0d start %b end %b, ",
                                  "want byte %h kind %0d start %b end %b"},
                                 got_res.byte_out, got_res.token_kind,
                                 got_res.starts_token, got_res.stream_end,
                                 want_res.byte_out, want_res.token_kind,
                                 want_res.starts_token, want_res.stream_end);
                end
            end
        end
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[sexpr_byte_tokenizer_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_lexeme_mix(0, 0);
        test_lexeme_mix(56, 0);
        test_lexeme_mix(0, 56);
        test_lexeme_mix(10, 10);
        test_output_full();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && label_q.size() == 0)
            $display("[sexpr_byte_tokenizer_core] OK");
        else
            $display("[sexpr_byte_tokenizer_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
